// File: src/b64r_pkg.sv
// Shared types, constants and lookup functions for the reference-to-hex decoder.
`default_nettype none

package b64r_pkg;

  localparam int unsigned POS_W      = 6;
  localparam logic [POS_W-1:0] POS_MAX      = 6'd63;
  localparam logic [POS_W-1:0] POS_HDR_HI   = 6'd1;
  localparam logic [POS_W-1:0] POS_FIRST_PL = 6'd2;
  localparam logic [POS_W-1:0] POS_LAST     = 6'd44;

  localparam logic [7:0] HDR_CHAR0 = 8'h48;
  localparam logic [7:0] HDR_CHAR1 = 8'h31;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  localparam logic [4:0] SEQ_PREFIX_END = 5'd15;
  localparam logic [4:0] SEQ_HEX_HI     = 5'd16;
  localparam logic [4:0] SEQ_HEX_LO     = 5'd17;
  localparam logic [4:0] SEQ_STATUS     = 5'd18;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_CORR = 2'd1,
    ST_INVALID  = 2'd2
  } status_e;

  // One unit of work handed from the front end to the output sequencer.
  typedef struct packed {
    logic       prefix_en;
    logic       byte_en;
    logic [7:0] data;
    logic       status_en;
    status_e    status;
  } job_t;

  // Returns {invalid, value} for a URL-safe base64 character.
  function automatic logic [6:0] sixbit_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    case (c) inside
      [8'h41:8'h5A]: v = c - 8'h41;
      [8'h61:8'h7A]: v = c - 8'h61 + 8'd26;
      [8'h30:8'h39]: v = c - 8'h30 + 8'd52;
      8'h2D:         v = 8'd62;
      8'h5F:         v = 8'd63;
      default:       v = 8'd64;
    endcase
    return v[6:0];
  endfunction

  // Lowercase hex digit.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'd0, n};
    end else begin
      r = 8'h57 + {4'd0, n};
    end
    return r;
  endfunction

  // Fixed sixteen-character text prefix.
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h68;
      4'd1:    r = 8'h65;
      4'd2:    r = 8'h70;
      4'd3:    r = 8'h74;
      4'd4:    r = 8'h61;
      4'd5:    r = 8'h2D;
      4'd6:    r = 8'h76;
      4'd7:    r = 8'h31;
      4'd8:    r = 8'h2D;
      4'd9:    r = 8'h73;
      4'd10:   r = 8'h68;
      4'd11:   r = 8'h61;
      4'd12:   r = 8'h32;
      4'd13:   r = 8'h35;
      4'd14:   r = 8'h36;
      4'd15:   r = 8'h3A;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/b64r_front.sv
// Front end: header check, base64 decode, byte assembly and status classification.
`default_nettype none

module b64r_front import b64r_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] ref_char_i,
  input  wire logic       last_char_i,
  output logic            push_o,
  output job_t            job_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [11:0]      buf_q, buf_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             hbad_q, hbad_d;
  logic             pbad_q, pbad_d;

  logic [6:0]  sx;
  logic        payload;
  logic        hbad_n, pbad_n;
  logic [11:0] buf_sh, buf_n;
  logic [3:0]  cnt_sum, cnt_n;
  logic        byte_done;
  logic [7:0]  byte_val;
  logic [11:0] keep_mask;

  always_comb begin
    sx      = sixbit_of(ref_char_i);
    payload = (pos_q >= POS_FIRST_PL) && (pos_q <= POS_LAST);
    hbad_n  = hbad_q
            | ((pos_q == '0) && (ref_char_i != HDR_CHAR0))
            | ((pos_q == POS_HDR_HI) && (ref_char_i != HDR_CHAR1));
    pbad_n  = pbad_q | (payload && sx[6]);

    buf_sh    = {buf_q[5:0], (sx[6] ? 6'd0 : sx[5:0])};
    cnt_sum   = cnt_q + 4'd6;
    byte_done = payload && (cnt_sum >= 4'd8);
    if (byte_done) begin
      cnt_n = cnt_sum - 4'd8;
    end else if (payload) begin
      cnt_n = cnt_sum;
    end else begin
      cnt_n = cnt_q;
    end

    // After a byte completes only zero, two or four bits remain.
    case (cnt_n)
      4'd2: begin
        byte_val  = buf_sh[9:2];
        keep_mask = 12'h003;
      end
      4'd4: begin
        byte_val  = buf_sh[11:4];
        keep_mask = 12'h00F;
      end
      default: begin
        byte_val  = buf_sh[7:0];
        keep_mask = 12'h000;
      end
    endcase

    if (byte_done) begin
      buf_n = buf_sh & keep_mask;
    end else if (payload) begin
      buf_n = buf_sh;
    end else begin
      buf_n = buf_q;
    end

    job_o.prefix_en = (pos_q == '0) && !last_char_i;
    job_o.byte_en   = byte_done && !hbad_n && !pbad_n;
    job_o.data      = byte_val;
    job_o.status_en = last_char_i;
    if ((pos_q != POS_LAST) || hbad_n) begin
      job_o.status = ST_NOT_CORR;
    end else if (pbad_n || (cnt_n != 4'd2) || (buf_n[1:0] != 2'b00)) begin
      job_o.status = ST_INVALID;
    end else begin
      job_o.status = ST_OK;
    end

    push_o = accept_i && (job_o.prefix_en || job_o.byte_en || job_o.status_en);

    pos_d  = pos_q;
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    hbad_d = hbad_q;
    pbad_d = pbad_q;
    if (accept_i) begin
      if (last_char_i) begin
        pos_d  = '0;
        buf_d  = '0;
        cnt_d  = '0;
        hbad_d = 1'b0;
        pbad_d = 1'b0;
      end else begin
        pos_d  = (pos_q < POS_MAX) ? pos_q + 6'd1 : pos_q;
        buf_d  = buf_n;
        cnt_d  = cnt_n;
        hbad_d = hbad_n;
        pbad_d = pbad_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      buf_q  <= '0;
      cnt_q  <= '0;
      hbad_q <= 1'b0;
      pbad_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      buf_q  <= buf_d;
      cnt_q  <= cnt_d;
      hbad_q <= hbad_d;
      pbad_q <= pbad_d;
    end
  end

endmodule

`default_nettype wire

// File: src/b64r_fifo.sv
// Small job queue between the front end and the output sequencer.
`default_nettype none

module b64r_fifo import b64r_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      valid_o,
  output job_t      job_o
);

  job_t            mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Q_AW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (Q_AW+1)'(push_i) - (Q_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Q_AW+1)'(Q_DEPTH))
    else $error("job queue count out of range");

endmodule

`default_nettype wire

// File: src/b64r_back.sv
// Output sequencer: expands queued jobs into prefix, hex and status requests.
`default_nettype none

module b64r_back import b64r_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  job_t            q_job_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_char_o,
  output logic            is_status_o,
  output logic [1:0]      status_o,
  output logic            last_o
);

  job_t       cur_q, cur_d;
  logic       cur_vld_q, cur_vld_d;
  logic [4:0] seq_q, seq_d;
  logic       ov_q, ov_d;
  logic [7:0] och_q, och_d;
  logic       ost_q, ost_d;
  logic [1:0] osc_q, osc_d;

  logic       emit, last_item;
  logic [4:0] seq_nx, seq_first;

  always_comb begin
    emit = cur_vld_q && (!ov_q || !out_stall_i);

    case (seq_q)
      SEQ_PREFIX_END: last_item = !cur_q.byte_en && !cur_q.status_en;
      SEQ_HEX_LO:     last_item = !cur_q.status_en;
      SEQ_STATUS:     last_item = 1'b1;
      default:        last_item = 1'b0;
    endcase

    case (seq_q)
      SEQ_PREFIX_END: seq_nx = cur_q.byte_en ? SEQ_HEX_HI : SEQ_STATUS;
      SEQ_HEX_HI:     seq_nx = SEQ_HEX_LO;
      SEQ_HEX_LO:     seq_nx = SEQ_STATUS;
      default:        seq_nx = seq_q + 5'd1;
    endcase

    if (q_job_i.prefix_en) begin
      seq_first = '0;
    end else if (q_job_i.byte_en) begin
      seq_first = SEQ_HEX_HI;
    end else begin
      seq_first = SEQ_STATUS;
    end

    ov_d  = ov_q;
    och_d = och_q;
    ost_d = ost_q;
    osc_d = osc_q;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    if (emit) begin
      ov_d = 1'b1;
      if (seq_q == SEQ_STATUS) begin
        och_d = 8'h00;
        ost_d = 1'b1;
        osc_d = cur_q.status;
      end else begin
        ost_d = 1'b0;
        osc_d = ST_OK;
        if (seq_q == SEQ_HEX_HI) begin
          och_d = hex_char(cur_q.data[7:4]);
        end else if (seq_q == SEQ_HEX_LO) begin
          och_d = hex_char(cur_q.data[3:0]);
        end else begin
          och_d = prefix_char(seq_q[3:0]);
        end
      end
    end

    q_pop_o   = 1'b0;
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    seq_d     = emit ? seq_nx : seq_q;
    if (!cur_vld_q || (emit && last_item)) begin
      q_pop_o   = q_valid_i;
      cur_vld_d = q_valid_i;
      cur_d     = q_job_i;
      seq_d     = seq_first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      seq_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      seq_q     <= seq_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    och_q <= och_d;
    ost_q <= ost_d;
    osc_q <= osc_d;
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = och_q;
  assign is_status_o = ost_q;
  assign status_o    = osc_q;
  assign last_o      = ost_q;

endmodule

`default_nettype wire

// File: src/base64url_ref_to_hex_decoder.sv
// Path: a request goes through the job queue, the back end's current job and the output register.
// Throughput: one input request per cycle while the job queue has room; one result per cycle
// while out_stall_i is low. A payload character makes up to two hex results, so sustained intake is
// bounded by the single output register; the first character makes sixteen prefix results.
// Reset: asynchronous, active low; clears position, bit buffer, flags, queue and output valid.
// No clearing pass is needed; the block accepts requests in the first cycle after reset.
`default_nettype none

module base64url_ref_to_hex_decoder import b64r_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] ref_char_i,
  input  wire logic       last_char_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_char_o,
  output logic            is_status_o,
  output logic [1:0]      status_o,
  output logic            last_o
);

  // The front end holds all per-reference state and turns each accepted
  // character into at most one job: prefix, one decoded byte, a status, or a
  // byte followed by a status. Characters that yield nothing push no job.
  logic accept;
  logic push;
  job_t push_job;

  // The queue decouples intake from output so a stalled consumer does not
  // stop intake until four jobs are waiting.
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t q_job;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  b64r_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .ref_char_i  (ref_char_i),
    .last_char_i (last_char_i),
    .push_o      (push),
    .job_o       (push_job)
  );

  b64r_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  // The back end walks each job item by item into a registered output stage,
  // which holds a finished result while the consumer stalls.
  b64r_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (q_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .is_status_o (is_status_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// File: test/b64r_decode_checker.sv
// Stream checker for the reference-to-hex decoder: predicts every result and compares it.

module b64r_decode_checker import b64r_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] ref_char_i,
  input  logic       last_char_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_char_i,
  input  logic       is_status_i,
  input  logic [1:0] status_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       is_st;
    status_e    st;
    logic       lst;
  } corr_item_t;

  // The fixed text that opens every correlation string, first character in the top byte.
  localparam logic [127:0] TEXT_PREFIX = 128'h6865_7074_612d_7631_2d73_6861_3235_363a;

  corr_item_t expected_corr_q[$];

  logic [5:0]  next_pos;
  logic [11:0] pend_bits;
  logic [3:0]  pend_count;
  logic        hdr_err;
  logic        pl_err;

  // Bit 6 set means the character is in the URL-safe alphabet; bits 5:0 hold its value.
  function automatic logic [6:0] sextet(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2D) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h5F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_lc(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + 8'(n);
    end else begin
      r = 8'h61 + 8'(n) - 8'd10;
    end
    return r;
  endfunction

  function automatic corr_item_t char_item(input logic [7:0] c);
    corr_item_t it;
    it.ch    = c;
    it.is_st = 1'b0;
    it.st    = ST_OK;
    it.lst   = 1'b0;
    return it;
  endfunction

  // Appends one predicted result at the tail of the queue.
  task automatic expect_item(input corr_item_t it);
    expected_corr_q.insert(expected_corr_q.size(), it);
  endtask

  task automatic clear_decode_state();
    next_pos   = '0;
    pend_bits  = '0;
    pend_count = '0;
    hdr_err    = 1'b0;
    pl_err     = 1'b0;
  endtask

  // Works out the results one accepted reference character causes.
  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [5:0] pos;
    logic [6:0] sx;
    logic [7:0] octet;
    corr_item_t st_item;
    pos = next_pos;
    if (pos == '0) begin
      if (c != HDR_CHAR0) hdr_err = 1'b1;
      if (!fin) begin
        for (int i = 0; i < 16; i++) begin
          expect_item(char_item(TEXT_PREFIX[127 - 8*i -: 8]));
        end
      end
    end else if (pos == POS_HDR_HI) begin
      if (c != HDR_CHAR1) hdr_err = 1'b1;
    end else if (pos <= POS_LAST) begin
      sx = sextet(c);
      if (!sx[6]) pl_err = 1'b1;
      pend_bits  = {pend_bits[5:0], (sx[6] ? sx[5:0] : 6'd0)};
      pend_count = pend_count + 4'd6;
      if (pend_count >= 4'd8) begin
        pend_count = pend_count - 4'd8;
        octet      = 8'(pend_bits >> pend_count);
        pend_bits  = pend_bits & ((12'd1 << pend_count) - 12'd1);
        if (!hdr_err && !pl_err) begin
          expect_item(char_item(hex_lc(octet[7:4])));
          expect_item(char_item(hex_lc(octet[3:0])));
        end
      end
    end
    if (next_pos != POS_MAX) next_pos = next_pos + 6'd1;
    if (fin) begin
      st_item.ch    = 8'd0;
      st_item.is_st = 1'b1;
      st_item.lst   = 1'b1;
      if (pos != POS_LAST || hdr_err) begin
        st_item.st = ST_NOT_CORR;
      end else if (pl_err || pend_count != 4'd2 || pend_bits[1:0] != 2'b00) begin
        st_item.st = ST_INVALID;
      end else begin
        st_item.st = ST_OK;
      end
      expect_item(st_item);
      clear_decode_state();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    corr_item_t exp_item;
    if (!rst_ni) begin
      clear_decode_state();
      expected_corr_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        decode_char(ref_char_i, last_char_i);
      end
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (expected_corr_q.size() == 0) begin
          $error("unexpected result: out_char %h is_status %b status %0d last %b",
                 out_char_i, is_status_i, status_i, last_i);
          fail_count_o++;
        end else begin
          exp_item = expected_corr_q.pop_front();
          if (out_char_i != exp_item.ch) begin
            $error("out_char mismatch: expected %h, actual %h", exp_item.ch, out_char_i);
            fail_count_o++;
          end
          if (is_status_i != exp_item.is_st) begin
            $error("is_status mismatch: expected %b, actual %b", exp_item.is_st, is_status_i);
            fail_count_o++;
          end
          if (status_i != exp_item.st) begin
            $error("status mismatch: expected %0d, actual %0d", exp_item.st, status_i);
            fail_count_o++;
          end
          if (last_i != exp_item.lst) begin
            $error("last mismatch: expected %b, actual %b", exp_item.lst, last_i);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_corr_q.size();
    end
  end

endmodule

// File: test/base64url_ref_to_hex_decoder_tb.sv
// Top of the decoder testbench: clock, reset, reference stimulus, stall pattern and verdict.

module base64url_ref_to_hex_decoder_tb;
  import b64r_pkg::*;

  // Random characters after the directed requests; the loop also runs until every
  // well-formed variant has been sent at least once.
  localparam int RANDOM_GOAL  = 120;
  localparam int WF_VARIANTS  = 3;
  // A short drain is plenty to catch any result beyond the predicted ones.
  localparam int DRAIN_CYCLES = 20;
  // The limit leaves a wide margin over the length of a correct run.
  localparam int CYCLE_LIMIT  = 200000;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] ref_char_i;
  logic       last_char_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_char_o;
  logic       is_status_o;
  logic [1:0] status_o;
  logic       last_o;

  int fail_count;
  int pending;
  int checked;
  int cycle_count;

  // While calm is set neither side idles, giving a stretch at full rate.
  logic calm;

  int chars_sent;
  int refs_sent;
  int full_refs;

  // Characters of the reference being built; noise ones may run up to five past the full length.
  logic [7:0] ref_buf [50];

  base64url_ref_to_hex_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ref_char_i  (ref_char_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .is_status_o (is_status_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  b64r_decode_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .ref_char_i   (ref_char_i),
    .last_char_i  (last_char_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_i   (out_char_o),
    .is_status_i  (is_status_o),
    .status_i     (status_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung handshake: the run is cut off well past any correct length.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The result side stalls at random with a chance of 27 percent, except in the calm stretch.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= !calm && ($urandom_range(99) < 27);
    end
  end

  // Character of the URL-safe alphabet with the given 6-bit value.
  function automatic logic [7:0] url_char(input int idx);
    logic [7:0] c;
    if (idx < 26) begin
      c = 8'h41 + 8'(idx);
    end else if (idx < 52) begin
      c = 8'h61 + 8'(idx - 26);
    end else if (idx < 62) begin
      c = 8'h30 + 8'(idx - 52);
    end else if (idx == 62) begin
      c = 8'h2D;
    end else begin
      c = 8'h5F;
    end
    return c;
  endfunction

  function automatic logic is_url_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h5F;
  endfunction

  // A random byte that lies outside the alphabet.
  function automatic logic [7:0] stray_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_url_char(c));
    return c;
  endfunction

  // Offers one character and returns once the block has taken the request. Valid is
  // only lowered when an idle gap is inserted, so back-to-back requests keep it high.
  // Each cycle idles on its own draw, with a chance of 27 percent.
  task automatic push_char(input logic [7:0] c, input logic fin);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    ref_char_i  <= c;
    last_char_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
  endtask

  task automatic send_ref(input int len);
    for (int i = 0; i < len; i++) begin
      push_char(ref_buf[i], i == len - 1);
    end
    refs_sent++;
  endtask

  // Builds a 45-character reference with a correct header and payload whose final
  // character leaves two zero bits, so it decodes cleanly unless altered afterwards.
  task automatic build_clean_ref();
    ref_buf[0] = HDR_CHAR0;
    ref_buf[1] = HDR_CHAR1;
    for (int i = 2; i < 44; i++) begin
      ref_buf[i] = url_char($urandom_range(63));
    end
    ref_buf[44] = url_char($urandom_range(15) * 4);
  endtask

  initial begin : stimulus
    int len;
    int wf_count;
    int random_start;
    int variant;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    ref_char_i  = 8'd0;
    last_char_i = 1'b0;
    calm        = 1'b0;
    chars_sent  = 0;
    refs_sent   = 0;
    full_refs   = 0;
    wf_count    = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // A lone header character is also the final one: no prefix, only the status.
    ref_buf[0] = HDR_CHAR0;
    send_ref(1);
    ref_buf[0] = 8'hFF;
    send_ref(1);
    // Correct header that ends before any payload.
    ref_buf[0] = HDR_CHAR0;
    ref_buf[1] = HDR_CHAR1;
    send_ref(2);
    // A zero byte in the payload, but the short length wins and reports not-a-correlation.
    ref_buf[2] = 8'h00;
    send_ref(3);
    // The alphabet's extremes decode to hex before the reference is cut short.
    ref_buf[2] = url_char(0);
    ref_buf[3] = url_char(63);
    ref_buf[4] = url_char(51);
    ref_buf[5] = url_char(61);
    ref_buf[6] = url_char(62);
    send_ref(7);
    // A bad first or second header character suppresses every hex result.
    ref_buf[0] = 8'h68;
    ref_buf[1] = HDR_CHAR1;
    ref_buf[2] = url_char(7);
    ref_buf[3] = url_char(40);
    send_ref(4);
    ref_buf[0] = HDR_CHAR0;
    ref_buf[1] = 8'h30;
    send_ref(4);

    // Random part. Most references are full length with random content; a rotation of
    // variants makes sure the clean case, bad trailing bits and a stray character appear.
    random_start = chars_sent;
    while (chars_sent - random_start < RANDOM_GOAL || wf_count < WF_VARIANTS) begin
      calm = (chars_sent - random_start >= 50) && (chars_sent - random_start < 110);
      if ($urandom_range(99) < 75) begin
        build_clean_ref();
        len = 45;
        variant = wf_count % WF_VARIANTS;
        case (variant)
          1: begin
            // The two leftover bits are not both zero.
            ref_buf[44] = url_char($urandom_range(15) * 4 + $urandom_range(1, 3));
          end
          2: begin
            // One character outside the alphabet stops the hex output from there on.
            ref_buf[$urandom_range(2, 44)] = stray_byte();
          end
          default: begin
          end
        endcase
        wf_count++;
        if (len == 45) full_refs++;
      end else begin
        // Noise: a random length, sometimes behind a correct header, with raw bytes
        // mixed into alphabet characters.
        len = $urandom_range(1, 50);
        for (int i = 0; i < len; i++) begin
          ref_buf[i] = $urandom_range(1) ? 8'($urandom_range(255)) : url_char($urandom_range(63));
        end
        if ($urandom_range(1)) begin
          ref_buf[0] = HDR_CHAR0;
          if (len > 1) ref_buf[1] = HDR_CHAR1;
        end
      end
      send_ref(len);
    end
    calm = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Wait for every predicted result, then a short drain to catch anything extra.
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d references in %0d characters, %0d of them full length.",
             refs_sent, chars_sent, full_refs);
    $display("Checked %0d result items, %0d mismatches.", checked, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
